>>> sv/swr_pkg.sv
// Shared types, constants and the character mapping of the symbol width regrouper.
`default_nettype none
package swr_pkg;

   localparam int MAX_SYMBOL_WIDTH_DEFAULT = 8;
   localparam int MAX_RESULTS = 8;
   localparam int ACC_LIMIT_BITS = 40;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INPUT_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_WIDTH = 2'd1;
   localparam logic [CSR_DATA_WIDTH-1:0] INPUT_WIDTH_RESET = 4'd8;
   localparam logic [CSR_DATA_WIDTH-1:0] OUTPUT_WIDTH_RESET = 4'd6;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   localparam logic [7:0] CHAR_UPPER_BASE = 8'h41;
   localparam logic [7:0] CHAR_LOWER_BASE = 8'(8'h61 - 8'd26);
   localparam logic [7:0] CHAR_DIGIT_BASE = 8'(8'h30 - 8'd52);
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic load_data;
      logic clear;
      logic emit;
      logic flush_emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic can_emit;
      logic last;
      logic residue;
      logic out_free;
   } ctrl_status_type;

   function automatic logic [7:0] b64url_char(input logic [15:0] value);
      logic [7:0] v8;
      v8 = value[7:0];
      if (value < 16'd26) begin
         return 8'(CHAR_UPPER_BASE + v8);
      end else if (value < 16'd52) begin
         return 8'(CHAR_LOWER_BASE + v8);
      end else if (value < 16'd62) begin
         return 8'(CHAR_DIGIT_BASE + v8);
      end else if (value == 16'd62) begin
         return CHAR_DASH;
      end
      return CHAR_UNDERSCORE;
   endfunction

endpackage
`default_nettype wire

>>> sv/swr_interfaces.sv
// Valid/ready channel interfaces for the request, response and register write ports.
`default_nettype none
interface swr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] in_symbol;
   modport source(output valid, kind, in_symbol, input ready);
   modport sink(input valid, kind, in_symbol, output ready);
endinterface

interface swr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_symbol;
   logic [7:0] out_char;
   logic       last_of_run;
   modport source(output valid, out_symbol, out_char, last_of_run, input ready);
   modport sink(input valid, out_symbol, out_char, last_of_run, output ready);
endinterface

interface swr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [swr_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [swr_pkg::CSR_DATA_WIDTH-1:0]  data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/symbol_width_regrouper_top.sv
// Top level of the symbol width regrouper: controller, datapath and channel ports.
// A request beat is accepted only in the idle state; the block then emits every result
// it causes (up to eight, one response beat per cycle while the response slot is free)
// before it takes the next beat. A data beat that completes no symbol passes through the
// emit state with no result, and a flush with a residue passes through the flush state.
// The response register can be loaded with the next beat in the same cycle the previous
// one is taken; while a beat waits unaccepted, the emit step stalls.
`default_nettype none
module symbol_width_regrouper_top #(
   parameter int MAX_SYMBOL_WIDTH = swr_pkg::MAX_SYMBOL_WIDTH_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   swr_req_if.sink    req_bus,
   swr_rsp_if.source  rsp_bus,
   swr_csr_if.sink    csr_bus
);

   swr_pkg::ctrl_cmd_type    cmd;
   swr_pkg::ctrl_status_type status;
   logic                     ctrl_req_ready;

   assign req_bus.ready = ctrl_req_ready;

   swr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (ctrl_req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swr_datapath #(
      .MAX_SYMBOL_WIDTH (MAX_SYMBOL_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_symbol (req_bus.in_symbol),
      .cmd       (cmd),
      .status    (status),
      .csr_bus   (csr_bus),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

>>> sv/swr_controller.sv
// Sequencer that accepts a beat and steps the datapath through its emissions.
`default_nettype none
module swr_controller (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_kind,
   output logic                          req_ready,
   input  wire swr_pkg::ctrl_status_type status,
   output swr_pkg::ctrl_cmd_type         cmd
);

   swr_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         swr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == swr_pkg::KIND_DATA) begin
                  cmd.load_data = 1'b1;
                  state_in = swr_pkg::ST_EMIT;
               end else if (status.residue) begin
                  state_in = swr_pkg::ST_FLUSH;
               end else begin
                  cmd.clear = 1'b1;
               end
            end
         end
         swr_pkg::ST_EMIT: begin
            if (!status.can_emit) begin
               state_in = swr_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last) begin
                  state_in = swr_pkg::ST_IDLE;
               end
            end
         end
         swr_pkg::ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush_emit = 1'b1;
               state_in = swr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> sv/swr_datapath.sv
// Width registers, bit accumulator, result counter and response register.
`default_nettype none
module swr_datapath #(
   parameter int MAX_SYMBOL_WIDTH = swr_pkg::MAX_SYMBOL_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             in_symbol,
   input  wire swr_pkg::ctrl_cmd_type  cmd,
   output swr_pkg::ctrl_status_type    status,
   swr_csr_if.sink                     csr_bus,
   swr_rsp_if.source                   rsp_bus
);

   localparam int AccBits = (MAX_SYMBOL_WIDTH <= swr_pkg::MAX_RESULTS) ?
                            2 * MAX_SYMBOL_WIDTH - 1 : swr_pkg::ACC_LIMIT_BITS;
   localparam int HeldW = $clog2(AccBits + 1);
   localparam int CntW = $clog2(swr_pkg::MAX_RESULTS);
   localparam int WidthCap = (MAX_SYMBOL_WIDTH < 15) ? MAX_SYMBOL_WIDTH : 15;
   localparam logic [3:0] WidthCapCode = 4'(WidthCap);
   localparam logic [HeldW:0] AccLimit = (HeldW + 1)'(AccBits);
   localparam logic [CntW-1:0] LastCount = CntW'(swr_pkg::MAX_RESULTS - 1);

   logic [3:0]                  in_width_ff, in_width_in;
   logic [3:0]                  out_width_ff, out_width_in;
   logic [3:0]                  iw, ow;
   logic [7:0]                  sym_mask, sym_in;
   logic [AccBits-1:0]          acc_ff, acc_in, acc_add;
   logic [HeldW-1:0]            held_ff, held_in, held_add, held_rest, ow_held;
   logic [HeldW:0]              held_sum;
   logic [CntW-1:0]             cnt_ff, cnt_in;
   logic [MAX_SYMBOL_WIDTH-1:0] out_mask, emit_sym;
   logic [15:0]                 emit_wide;
   logic                        last_now;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        last_ff, last_in;
   logic [7:0]                  sym_ff, sym_out_in, char_ff, char_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      in_width_in = in_width_ff;
      out_width_in = out_width_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            swr_pkg::CSR_INPUT_WIDTH: in_width_in = csr_bus.data;
            swr_pkg::CSR_OUTPUT_WIDTH: out_width_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   assign iw = (in_width_ff == 4'd0) ? 4'd1 :
               ((in_width_ff > WidthCapCode) ? WidthCapCode : in_width_ff);
   assign ow = (out_width_ff == 4'd0) ? 4'd1 :
               ((out_width_ff > WidthCapCode) ? WidthCapCode : out_width_ff);
   assign ow_held = HeldW'(ow);

   assign sym_mask = (iw >= 4'd8) ? 8'hFF : 8'((9'd1 << iw) - 9'd1);
   assign sym_in = in_symbol & sym_mask;
   assign acc_add = acc_ff | (AccBits'(sym_in) << held_ff);
   assign held_sum = {1'b0, held_ff} + (HeldW + 1)'(iw);
   assign held_add = (held_sum > AccLimit) ? HeldW'(AccBits) : held_sum[HeldW-1:0];
   assign held_rest = held_ff - ow_held;

   assign out_mask = MAX_SYMBOL_WIDTH'(((MAX_SYMBOL_WIDTH + 1)'(1) << ow) -
                                       (MAX_SYMBOL_WIDTH + 1)'(1));
   assign emit_sym = acc_ff[MAX_SYMBOL_WIDTH-1:0] & out_mask;
   assign emit_wide = 16'(emit_sym);
   assign last_now = (held_rest < ow_held) || (cnt_ff == LastCount);

   assign status.can_emit = (held_ff >= ow_held);
   assign status.last = last_now;
   assign status.residue = (iw > ow) && (held_ff != '0);
   assign status.out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      acc_in = acc_ff;
      held_in = held_ff;
      cnt_in = cnt_ff;
      if (cmd.load_data) begin
         acc_in = acc_add;
         held_in = held_add;
         cnt_in = '0;
      end else if (cmd.emit) begin
         acc_in = acc_ff >> ow;
         held_in = held_rest;
         cnt_in = cnt_ff + CntW'(1);
      end else if (cmd.clear || cmd.flush_emit) begin
         acc_in = '0;
         held_in = '0;
         cnt_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      sym_out_in = sym_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.emit || cmd.flush_emit) begin
         rsp_valid_in = 1'b1;
         sym_out_in = emit_wide[7:0];
         char_in = swr_pkg::b64url_char(emit_wide);
         last_in = cmd.flush_emit | last_now;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff <= swr_pkg::INPUT_WIDTH_RESET;
         out_width_ff <= swr_pkg::OUTPUT_WIDTH_RESET;
         acc_ff <= '0;
         held_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_width_ff <= in_width_in;
         out_width_ff <= out_width_in;
         acc_ff <= acc_in;
         held_ff <= held_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_out_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_symbol = sym_ff;
   assign rsp_bus.out_char = char_ff;
   assign rsp_bus.last_of_run = last_ff;

   a_emit_when_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.can_emit && status.out_free)
      else $error("emit issued without enough held bits or a free response slot");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_emit |=> held_ff == '0 && rsp_valid_ff && last_ff)
      else $error("flush did not clear the accumulator or mark the last beat");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff && held_ff == $past(held_rest))
      else $error("emitted symbol not presented or held count not advanced");

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the symbol width regrouper: directed table, random phases, predictor.
`timescale 1ns / 1ps
module testbench;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES = 7;
   localparam int ITEMS_PER_PHASE = 14;
   localparam int MAX_WIDTH = swr_pkg::MAX_SYMBOL_WIDTH_DEFAULT;
   localparam int IDX_W = swr_pkg::CSR_INDEX_WIDTH;
   localparam int DATA_W = swr_pkg::CSR_DATA_WIDTH;
   localparam logic [IDX_W-1:0] IDX_IN = swr_pkg::CSR_INPUT_WIDTH;
   localparam logic [IDX_W-1:0] IDX_OUT = swr_pkg::CSR_OUTPUT_WIDTH;

   typedef enum {ROW_DATA, ROW_FLUSH, ROW_CSR} row_kind_type;
   typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE} check_mode_type;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      row_kind_type     op;
      logic [IDX_W-1:0] idx;
      logic [7:0]       value;
      check_mode_type   check;
      logic [7:0]       t_sym;
      logic [7:0]       t_char;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic [7:0] ch;
      logic       last;
   } symbol_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swr_req_if req_bus();
   swr_rsp_if rsp_bus();
   swr_csr_if csr_bus();

   symbol_width_regrouper_top dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [DATA_W-1:0] in_width_reg = swr_pkg::INPUT_WIDTH_RESET;
   logic [DATA_W-1:0] out_width_reg = swr_pkg::OUTPUT_WIDTH_RESET;
   logic [63:0]       gear_acc = '0;
   int unsigned       gear_bits = 0;

   symbol_beat_type pending_symbols[$];
   stim_row_type    directed_rows[$];
   int              error_count = 0;
   int              sender_idle_pct = 0;
   int              rsp_stall_pct = 0;
   logic            rsp_hold = 1'b0;
   event            hold_start;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = swr_pkg::KIND_DATA;
      req_bus.in_symbol = 8'h00;
      csr_bus.valid = 1'b0;
      csr_bus.index = IDX_IN;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic int unsigned clamp_width(input logic [DATA_W-1:0] w);
      if (w == 0) return 1;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return 32'(w);
   endfunction

   function automatic logic [7:0] url_char(input logic [63:0] v);
      if (v < 26) return 8'(swr_pkg::CHAR_UPPER_BASE + v[7:0]);
      if (v < 52) return 8'(swr_pkg::CHAR_LOWER_BASE + v[7:0]);
      if (v < 62) return 8'(swr_pkg::CHAR_DIGIT_BASE + v[7:0]);
      if (v == 62) return swr_pkg::CHAR_DASH;
      return swr_pkg::CHAR_UNDERSCORE;
   endfunction

   function automatic symbol_beat_type make_beat(input logic [63:0] v);
      symbol_beat_type b;
      b.symbol = v[7:0];
      b.ch = url_char(v);
      b.last = 1'b0;
      return b;
   endfunction

   task automatic regroup_beat(input logic kind, input logic [7:0] sym, input bit keep);
      int unsigned     iw;
      int unsigned     ow;
      logic [63:0]     omask;
      symbol_beat_type beats[$];
      iw = clamp_width(in_width_reg);
      ow = clamp_width(out_width_reg);
      omask = (64'd1 << ow) - 64'd1;
      if (kind == swr_pkg::KIND_FLUSH) begin
         if (iw > ow && gear_bits > 0) beats.push_back(make_beat(gear_acc & omask));
         gear_acc = '0;
         gear_bits = 0;
      end else begin
         gear_acc |= (64'(sym) & ((64'd1 << iw) - 64'd1)) << gear_bits;
         gear_bits += iw;
         if (gear_bits > swr_pkg::ACC_LIMIT_BITS) gear_bits = swr_pkg::ACC_LIMIT_BITS;
         gear_acc &= (64'd1 << gear_bits) - 64'd1;
         while (gear_bits >= ow && beats.size() < swr_pkg::MAX_RESULTS) begin
            beats.push_back(make_beat(gear_acc & omask));
            gear_acc >>= ow;
            gear_bits -= ow;
         end
      end
      if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
      if (keep) foreach (beats[i]) pending_symbols.push_back(beats[i]);
   endtask

   task automatic flag_error(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_beat(input logic kind, input logic [7:0] sym, input check_mode_type check,
                            input logic [7:0] t_sym, input logic [7:0] t_char);
      symbol_beat_type b;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.kind = kind;
      req_bus.in_symbol = sym;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      regroup_beat(kind, sym, check == CHK_MODEL);
      if (check == CHK_ONE) begin
         b.symbol = t_sym;
         b.ch = t_char;
         b.last = 1'b1;
         pending_symbols.push_back(b);
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == IDX_IN) in_width_reg = value;
      else if (idx == IDX_OUT) out_width_reg = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 87;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            rsp_stall_pct = 87;
         end
         default: begin
            sender_idle_pct = 13;
            rsp_stall_pct = 13;
         end
      endcase
   endtask

   function automatic stim_row_type mk_row(input row_kind_type op, input logic [IDX_W-1:0] idx,
                                           input logic [7:0] value, input check_mode_type check,
                                           input logic [7:0] t_sym, input logic [7:0] t_char);
      stim_row_type r;
      r.op = op;
      r.idx = idx;
      r.value = value;
      r.check = check;
      r.t_sym = t_sym;
      r.t_char = t_char;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] random_width();
      if ($urandom_range(0, 3) == 0) return DATA_W'($urandom_range(0, 15));
      return DATA_W'($urandom_range(1, 8));
   endfunction

   task automatic build_directed();
      // reset widths 8 in, 6 out
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h00, CHK_ONE,   8'h00, "A"));
      directed_rows.push_back(mk_row(ROW_FLUSH, '0, 8'h00, CHK_ONE,   8'h00, "A"));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'hFF, CHK_ONE,   8'h3F, "_"));
      directed_rows.push_back(mk_row(ROW_FLUSH, '0, 8'h00, CHK_ONE,   8'h03, "D"));
      directed_rows.push_back(mk_row(ROW_FLUSH, '0, 8'h00, CHK_NONE,  8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h4D, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h61, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h6E, CHK_MODEL, 8'h00, 8'h00));
      // zero input width, output width above maximum
      directed_rows.push_back(mk_row(ROW_CSR, IDX_IN,  8'h0, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_CSR, IDX_OUT, 8'hF, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'hFE, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'hFF, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_FLUSH, '0, 8'h00, CHK_NONE,  8'h00, 8'h00));
      // widest input, narrowest output: most results per beat
      directed_rows.push_back(mk_row(ROW_CSR, IDX_IN,  8'hF, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_CSR, IDX_OUT, 8'h0, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'hA5, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'hFF, CHK_MODEL, 8'h00, 8'h00));
      // too few bits, then widen the input with bits held
      directed_rows.push_back(mk_row(ROW_CSR, IDX_IN,  8'h3, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_CSR, IDX_OUT, 8'h5, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h07, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_CSR, IDX_IN,  8'h7, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h55, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h2A, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_FLUSH, '0, 8'h00, CHK_MODEL, 8'h00, 8'h00));
      // unmapped register indexes
      directed_rows.push_back(mk_row(ROW_CSR, 2'd2, 8'h9, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_CSR, 2'd3, 8'h6, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h80, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_FLUSH, '0, 8'h00, CHK_MODEL, 8'h00, 8'h00));
      // byte in, byte out: character boundaries
      directed_rows.push_back(mk_row(ROW_CSR, IDX_OUT, 8'h8, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_CSR, IDX_IN,  8'h8, CHK_MODEL, 8'h00, 8'h00));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h3E, CHK_ONE,   8'h3E, "-"));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h40, CHK_ONE,   8'h40, "_"));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h19, CHK_ONE,   8'h19, "Z"));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h1A, CHK_ONE,   8'h1A, "a"));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h34, CHK_ONE,   8'h34, "0"));
      directed_rows.push_back(mk_row(ROW_DATA,  '0, 8'h3D, CHK_ONE,   8'h3D, "9"));
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   initial begin
      @(hold_start);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin
      symbol_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_symbols.size() == 0) begin
            flag_error($sformatf("unexpected result symbol %0h", rsp_bus.out_symbol));
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_bus.out_symbol !== want.symbol)
               flag_error($sformatf("out_symbol got %0h want %0h", rsp_bus.out_symbol,
                                    want.symbol));
            if (rsp_bus.out_char !== want.ch)
               flag_error($sformatf("out_char got %0h want %0h", rsp_bus.out_char, want.ch));
            if (rsp_bus.last_of_run !== want.last)
               flag_error($sformatf("last_of_run got %0b want %0b", rsp_bus.last_of_run,
                                    want.last));
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("symbol_width_regrouper_top regression: fail");
      $finish;
   end

   initial begin
      logic       kind;
      logic [7:0] sym;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      build_directed();
      set_idle(IDLE_NONE);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_CSR) begin
            wait_drained();
            write_csr(directed_rows[i].idx, directed_rows[i].value[DATA_W-1:0]);
         end else begin
            send_beat(directed_rows[i].op == ROW_FLUSH ? swr_pkg::KIND_FLUSH
                                                       : swr_pkg::KIND_DATA,
                      directed_rows[i].value, directed_rows[i].check,
                      directed_rows[i].t_sym, directed_rows[i].t_char);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         if (p == 4) begin
            write_csr(IDX_IN, 4'd8);
            write_csr(IDX_OUT, 4'd1);
         end else begin
            write_csr(IDX_IN, random_width());
            write_csr(IDX_OUT, random_width());
         end
         set_idle(idle_mode_type'(p % 4));
         // hold the receiver off so the block backs up, then drain midway
         if (p == 4) begin
            set_idle(IDLE_NONE);
            -> hold_start;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 4 && n == ITEMS_PER_PHASE / 2) wait_drained();
            kind = ($urandom_range(0, 9) == 0) ? swr_pkg::KIND_FLUSH : swr_pkg::KIND_DATA;
            sym = 8'($urandom_range(0, 255));
            send_beat(kind, sym, CHK_MODEL, 8'h00, 8'h00);
         end
      end

      req_bus.valid = 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_symbols.size() == 0) begin
         $display("symbol_width_regrouper_top regression: pass");
      end else begin
         $display("symbol_width_regrouper_top regression: fail");
      end
      $finish;
   end

endmodule
